// File: rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W = 8;
   localparam int CFG_W  = 64;
   localparam int LEN_W  = 4;

   // register map of the configuration port
   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   // control part of one result burst
   typedef struct packed {
      logic [LEN_W-1:0] cnt;   // results in the burst, 1..8
      logic             dv;    // results carry data bytes
      logic             err;   // empty pattern error
      logic             eos;   // final burst of the stream
   } burst_ctl_type;

endpackage

`default_nettype wire

// File: rtl/sfr_cell.sv
`default_nettype none

module sfr_cell
   import sfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              sel,
   input  wire logic              shift,
   input  wire logic [BYTE_W-1:0] next_eff,
   input  wire logic [BYTE_W-1:0] pat_byte,
   input  wire logic              in_use,
   output logic      [BYTE_W-1:0] eff_byte,
   output logic                   hit
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   // window byte after the new byte is appended
   assign eff_byte = sel ? in_byte : byte_ff;
   assign hit      = !in_use || (eff_byte == pat_byte);

   // on a mismatch take the neighbor's byte, else keep our own
   assign byte_in = shift ? next_eff : eff_byte;

   always_ff @(posedge clock) begin
      if (en) begin
         byte_ff <= byte_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sfr_window.sv
`default_nettype none

module sfr_window
   import sfr_pkg::*;
#(
   parameter int LEN_CAP = 8
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [BYTE_W-1:0]         in_byte,
   input  wire logic                      stream_last,
   input  wire logic                      csr_write,
   input  wire logic [CFG_W-1:0]          pattern_bytes,
   input  wire logic [LEN_W-1:0]          pattern_length,
   input  wire logic [CFG_W-1:0]          replacement_bytes,
   input  wire logic [LEN_W-1:0]          replacement_length,
   output logic                           desc_valid,
   output burst_ctl_type                  desc_ctl,
   output logic      [LEN_CAP*BYTE_W-1:0] desc_data
);

   localparam logic [LEN_W-1:0] CAP_L = LEN_W'(LEN_CAP);

   logic [LEN_W-1:0]          held_ff;
   logic [LEN_W-1:0]          held_in;
   logic [LEN_W-1:0]          plen;
   logic [LEN_W-1:0]          rlen;
   logic [LEN_W-1:0]          held_eff;
   logic [LEN_W-1:0]          held_new;
   logic                      full;
   logic                      match;
   logic                      shift;
   logic [LEN_CAP-1:0]        hit_vec;
   logic [LEN_CAP*BYTE_W-1:0] eff_vec;

   // saturate lengths to the window size
   assign plen = (pattern_length > CAP_L) ? CAP_L : pattern_length;
   assign rlen = (replacement_length > CAP_L) ? CAP_L : replacement_length;

   assign held_eff = (held_ff >= plen) ? '0 : held_ff;
   assign held_new = held_eff + LEN_W'(1);
   assign full     = (held_new == plen);
   assign match    = &hit_vec;
   assign shift    = full && !match;

   // row of window cells, each compares against its pattern byte
   for (genvar k = 0; k < LEN_CAP; k++) begin : g_cell
      logic [BYTE_W-1:0] neighbor;
      if (k == LEN_CAP - 1) begin : g_end
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = eff_vec[(k+1)*BYTE_W +: BYTE_W];
      end
      sfr_cell u_cell (
         .clock    (clock),
         .en       (accept),
         .in_byte  (in_byte),
         .sel      (held_eff == LEN_W'(k)),
         .shift    (shift),
         .next_eff (neighbor),
         .pat_byte (pattern_bytes[k*BYTE_W +: BYTE_W]),
         .in_use   (LEN_W'(k) < plen),
         .eff_byte (eff_vec[k*BYTE_W +: BYTE_W]),
         .hit      (hit_vec[k])
      );
   end

   // fill count
   always_comb begin
      held_in = held_ff;
      if (csr_write) begin
         held_in = '0;
      end else if (accept) begin
         if (plen == '0 || stream_last || (full && match)) begin
            held_in = '0;
         end else if (full) begin
            held_in = held_eff;
         end else begin
            held_in = held_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // result burst caused by the accepted byte
   always_comb begin
      desc_valid   = 1'b0;
      desc_ctl     = '0;
      desc_data    = eff_vec;
      desc_ctl.eos = stream_last;
      if (accept) begin
         if (plen == '0) begin
            desc_valid   = 1'b1;
            desc_ctl.cnt = LEN_W'(1);
            desc_ctl.err = 1'b1;
         end else if (full && match) begin
            desc_data = replacement_bytes[LEN_CAP*BYTE_W-1:0];
            if (rlen != '0) begin
               desc_valid   = 1'b1;
               desc_ctl.cnt = rlen;
               desc_ctl.dv  = 1'b1;
            end else if (stream_last) begin
               // bare end marker
               desc_valid   = 1'b1;
               desc_ctl.cnt = LEN_W'(1);
            end
         end else if (full) begin
            desc_valid   = 1'b1;
            desc_ctl.cnt = stream_last ? plen : LEN_W'(1);
            desc_ctl.dv  = 1'b1;
         end else if (stream_last) begin
            desc_valid   = 1'b1;
            desc_ctl.cnt = held_new;
            desc_ctl.dv  = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/sfr_burst.sv
`default_nettype none

module sfr_burst
   import sfr_pkg::*;
#(
   parameter int LEN_CAP = 8
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      desc_valid,
   input  wire burst_ctl_type             desc_ctl,
   input  wire logic [LEN_CAP*BYTE_W-1:0] desc_data,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [BYTE_W-1:0]         rsp_out_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_run_last,
   output logic                           rsp_stream_end,
   output logic                           rsp_empty_pattern_error
);

   localparam int IDX_W = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;

   logic                      cur_valid_ff, cur_valid_in;
   burst_ctl_type             cur_ctl_ff, cur_ctl_in;
   logic [LEN_CAP*BYTE_W-1:0] cur_data_ff, cur_data_in;
   logic [IDX_W-1:0]          cur_idx_ff, cur_idx_in;
   logic                      nxt_valid_ff, nxt_valid_in;
   burst_ctl_type             nxt_ctl_ff, nxt_ctl_in;
   logic [LEN_CAP*BYTE_W-1:0] nxt_data_ff, nxt_data_in;
   logic                      xfer;
   logic                      last_beat;
   logic                      cur_free;

   assign xfer      = rsp_valid && !rsp_stall;
   assign last_beat = ({{(LEN_W-IDX_W){1'b0}}, cur_idx_ff} == cur_ctl_ff.cnt - LEN_W'(1));
   assign cur_free  = !cur_valid_ff || (xfer && last_beat);

   // input waits only while the spare burst slot is occupied
   assign req_stall = nxt_valid_ff;

   // current burst and spare slot
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_ctl_in   = cur_ctl_ff;
      cur_data_in  = cur_data_ff;
      cur_idx_in   = cur_idx_ff;
      nxt_valid_in = nxt_valid_ff;
      nxt_ctl_in   = nxt_ctl_ff;
      nxt_data_in  = nxt_data_ff;
      if (xfer && !last_beat) begin
         cur_idx_in = cur_idx_ff + IDX_W'(1);
      end
      if (cur_free) begin
         cur_idx_in = '0;
         if (nxt_valid_ff) begin
            cur_valid_in = 1'b1;
            cur_ctl_in   = nxt_ctl_ff;
            cur_data_in  = nxt_data_ff;
            nxt_valid_in = 1'b0;
         end else if (desc_valid) begin
            cur_valid_in = 1'b1;
            cur_ctl_in   = desc_ctl;
            cur_data_in  = desc_data;
         end else begin
            cur_valid_in = 1'b0;
         end
      end else if (desc_valid) begin
         nxt_valid_in = 1'b1;
         nxt_ctl_in   = desc_ctl;
         nxt_data_in  = desc_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         nxt_valid_ff <= 1'b0;
         cur_idx_ff   <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         nxt_valid_ff <= nxt_valid_in;
         cur_idx_ff   <= cur_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ctl_ff  <= cur_ctl_in;
      cur_data_ff <= cur_data_in;
      nxt_ctl_ff  <= nxt_ctl_in;
      nxt_data_ff <= nxt_data_in;
   end

   // result fields
   assign rsp_valid               = cur_valid_ff;
   assign rsp_byte_valid          = cur_ctl_ff.dv;
   assign rsp_out_byte            = cur_ctl_ff.dv ?
                                    cur_data_ff[cur_idx_ff*BYTE_W +: BYTE_W] : '0;
   assign rsp_run_last            = last_beat;
   assign rsp_stream_end          = cur_ctl_ff.eos && last_beat;
   assign rsp_empty_pattern_error = cur_ctl_ff.err;

   a_spare_implies_cur: assert property (@(posedge clock) disable iff (reset)
      nxt_valid_ff |-> cur_valid_ff)
      else $error("spare burst held with no current burst");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ctl_ff.cnt != '0) &&
                       ({{(LEN_W-IDX_W){1'b0}}, cur_idx_ff} < cur_ctl_ff.cnt))
      else $error("burst index beyond count");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && rsp_stall) |=> cur_valid_ff && $stable(cur_idx_ff))
      else $error("burst advanced while stalled");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      desc_valid |-> !nxt_valid_ff)
      else $error("new burst while spare slot full");

endmodule

`default_nettype wire

// File: rtl/stream_find_replace.sv
// stream_find_replace: find and replace over a byte stream.
// Request channel (req_valid/req_stall) carries one text byte and a
// last flag per transfer. Response channel (rsp_valid/rsp_stall) carries
// one result per transfer: an output byte, or a bare end marker or an
// error marker with rsp_byte_valid low. rsp_run_last marks the last result
// of one input byte, rsp_stream_end the final result of the stream.
// CSR channel (csr_valid/csr_ready, always ready) writes pattern bytes,
// pattern length, replacement bytes and replacement length; any write
// drops the held window bytes. Write only while the block is idle.
// Throughput: one input byte per cycle while req_stall is low. A byte that
// causes k results holds the response side until all are taken, one result
// per cycle while rsp_stall is low; a two-entry burst buffer after the
// compare row lets the next byte in meanwhile, and req_stall rises only when
// both entries are taken. A byte's first result is loaded into the current
// burst slot if it is free, else into the spare. The pattern compare is a
// row of cells, one per window byte. Reset zeroes the configuration
// registers and empties the window and burst buffer; no clearing pass is
// needed. A stalled receiver holds the current result steady until taken.

`default_nettype none

module stream_find_replace
   import sfr_pkg::*;
#(
   parameter int MAX_STRING_BYTES = 8
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_in_byte,
   input  wire logic              req_stream_last,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [BYTE_W-1:0] rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_run_last,
   output logic                   rsp_stream_end,
   output logic                   rsp_empty_pattern_error,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CFG_W-1:0]  csr_wdata
);

   localparam int LEN_CAP = (MAX_STRING_BYTES < 8) ? MAX_STRING_BYTES : 8;

   logic [CFG_W-1:0]          pattern_bytes_ff;
   logic [LEN_W-1:0]          pattern_length_ff;
   logic [CFG_W-1:0]          replacement_bytes_ff;
   logic [LEN_W-1:0]          replacement_length_ff;
   logic                      csr_write;
   logic                      accept;
   logic                      desc_valid;
   burst_ctl_type             desc_ctl;
   logic [LEN_CAP*BYTE_W-1:0] desc_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign accept    = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:      pattern_bytes_ff      <= csr_wdata;
            CSR_PATTERN_LENGTH:     pattern_length_ff     <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: replacement_length_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   sfr_window #(.LEN_CAP(LEN_CAP)) u_window (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .in_byte            (req_in_byte),
      .stream_last        (req_stream_last),
      .csr_write          (csr_write),
      .pattern_bytes      (pattern_bytes_ff),
      .pattern_length     (pattern_length_ff),
      .replacement_bytes  (replacement_bytes_ff),
      .replacement_length (replacement_length_ff),
      .desc_valid         (desc_valid),
      .desc_ctl           (desc_ctl),
      .desc_data          (desc_data)
   );

   sfr_burst #(.LEN_CAP(LEN_CAP)) u_burst (
      .clock                   (clock),
      .reset                   (reset),
      .desc_valid              (desc_valid),
      .desc_ctl                (desc_ctl),
      .desc_data               (desc_data),
      .req_stall               (req_stall),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_out_byte            (rsp_out_byte),
      .rsp_byte_valid          (rsp_byte_valid),
      .rsp_run_last            (rsp_run_last),
      .rsp_stream_end          (rsp_stream_end),
      .rsp_empty_pattern_error (rsp_empty_pattern_error)
   );

endmodule

`default_nettype wire

// File: tb/stream_find_replace_tb.sv
module stream_find_replace_tb
   import sfr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN_CAP        = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 300;

   // one result transfer as seen on the rsp_ side
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              dv;
      logic              run_last;
      logic              eos;
      logic              err;
   } text_result_type;

   // Tracks the find/replace window and queues the text the block owes us
   class replace_scoreboard;
      logic [CFG_W-1:0]  pat_word;
      logic [CFG_W-1:0]  rep_word;
      logic [LEN_W-1:0]  pat_len;
      logic [LEN_W-1:0]  rep_len;
      logic [BYTE_W-1:0] window [LEN_CAP];
      int                held;
      text_result_type   pending [$];
      int                errors;
      int                bytes_in;
      int                streams;
      int                results;
      int                replacements;

      function new();
         pat_word     = '0;
         rep_word     = '0;
         pat_len      = '0;
         rep_len      = '0;
         held         = 0;
         errors       = 0;
         bytes_in     = 0;
         streams      = 0;
         results      = 0;
         replacements = 0;
      endfunction

      function int clamp_len(logic [LEN_W-1:0] v);
         return (v > LEN_CAP) ? LEN_CAP : int'(v);
      endfunction

      function text_result_type data_result(logic [BYTE_W-1:0] b);
         text_result_type r;
         r = '{data: b, dv: 1'b1, run_last: 1'b0, eos: 1'b0, err: 1'b0};
         return r;
      endfunction

      // any register write drops the held window bytes
      function void write_reg(csr_index_type idx, logic [CFG_W-1:0] v);
         case (idx)
            CSR_PATTERN_BYTES:      pat_word = v;
            CSR_PATTERN_LENGTH:     pat_len  = v[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_word = v;
            CSR_REPLACEMENT_LENGTH: rep_len  = v[LEN_W-1:0];
            default: ;
         endcase
         held = 0;
      endfunction

      // accepted text byte: work out the results it causes
      function void note_byte(logic [BYTE_W-1:0] b, logic last);
         text_result_type burst [$];
         text_result_type r;
         int              plen;
         int              rlen;
         logic            hit;
         plen = clamp_len(pat_len);
         rlen = clamp_len(rep_len);
         bytes_in++;
         if (last) streams++;

         // empty pattern: error marker only
         if (plen == 0) begin
            held = 0;
            r = '{data: '0, dv: 1'b0, run_last: 1'b1, eos: last, err: 1'b1};
            pending.push_back(r);
            return;
         end

         if (held >= plen) held = 0;
         window[held] = b;
         held++;

         // full window: replace on a hit, else release the oldest byte
         if (held == plen) begin
            hit = 1'b1;
            for (int k = 0; k < plen; k++)
               if (window[k] != pat_word[8*k +: 8]) hit = 1'b0;
            if (hit) begin
               for (int k = 0; k < rlen; k++)
                  burst.push_back(data_result(rep_word[8*k +: 8]));
               held = 0;
               replacements++;
            end else begin
               burst.push_back(data_result(window[0]));
               for (int k = 1; k < plen; k++) window[k-1] = window[k];
               held--;
            end
         end

         // end of stream: flush, bare marker when nothing went out
         if (last) begin
            for (int k = 0; k < held; k++) burst.push_back(data_result(window[k]));
            held = 0;
            if (burst.size() == 0) begin
               r = '{data: '0, dv: 1'b0, run_last: 1'b0, eos: 1'b0, err: 1'b0};
               burst.push_back(r);
            end
            r = burst.pop_back();
            r.eos = 1'b1;
            burst.push_back(r);
         end

         if (burst.size() != 0) begin
            r = burst.pop_back();
            r.run_last = 1'b1;
            burst.push_back(r);
         end
         foreach (burst[i]) pending.push_back(burst[i]);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t ns  MISMATCH  %s", $time, what);
      endtask

      // compare one rsp_ transfer with the oldest pending result
      task check_output(text_result_type got);
         text_result_type want;
         results++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%02h dv=%0b last=%0b end=%0b err=%0b",
                                      got.data, got.dv, got.run_last, got.eos, got.err));
            return;
         end
         want = pending.pop_front();
         if (got.data !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.data, want.data));
         if (got.dv !== want.dv)
            report_mismatch($sformatf("byte_valid %0b, want %0b", got.dv, want.dv));
         if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b, want %0b", got.run_last, want.run_last));
         if (got.eos !== want.eos)
            report_mismatch($sformatf("stream_end %0b, want %0b", got.eos, want.eos));
         if (got.err !== want.err)
            report_mismatch($sformatf("empty_pattern_error %0b, want %0b", got.err, want.err));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_in_byte;
   logic              req_stream_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_byte_valid;
   logic              rsp_run_last;
   logic              rsp_stream_end;
   logic              rsp_empty_pattern_error;
   logic              csr_valid;
   logic              csr_ready;
   csr_index_type     csr_index;
   logic [CFG_W-1:0]  csr_wdata;

   replace_scoreboard sb;
   int unsigned       cycle_count = 0;
   int                quiet_cycles = 0;
   int                settings_used = 0;
   logic              steady;

   stream_find_replace dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_in_byte            (req_in_byte),
      .req_stream_last        (req_stream_last),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_byte_valid         (rsp_byte_valid),
      .rsp_run_last           (rsp_run_last),
      .rsp_stream_end         (rsp_stream_end),
      .rsp_empty_pattern_error(rsp_empty_pattern_error),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // recurring long window with no idling on either side
   assign steady = (cycle_count % 1000) >= 600;

   // random backpressure on the result side
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !steady && ($urandom_range(0, 99) < 18);
   end

   // every result transfer goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_output('{data: rsp_out_byte, dv: rsp_byte_valid, run_last: rsp_run_last,
                           eos: rsp_stream_end, err: rsp_empty_pattern_error});
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results still pending",
                  quiet_cycles, sb.pending.size());
         $display("stream_find_replace_tb: errors");
         $finish;
      end
   end

   // write all four registers back to back
   task automatic program_regs(logic [CFG_W-1:0] pat, logic [CFG_W-1:0] plen_w,
                               logic [CFG_W-1:0] rep, logic [CFG_W-1:0] rlen_w);
      csr_index_type    idx [4];
      logic [CFG_W-1:0] val [4];
      idx = '{CSR_PATTERN_BYTES, CSR_PATTERN_LENGTH, CSR_REPLACEMENT_BYTES,
              CSR_REPLACEMENT_LENGTH};
      val = '{pat, plen_w, rep, rlen_w};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // one text byte transfer, then maybe a short gap
   task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_stream_last <= last;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, last);
      if (!steady && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic send_text(logic [BYTE_W-1:0] text [$]);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // idle until every result is in, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // stream mostly built from whole and partial pattern copies
   task automatic random_stream(logic [CFG_W-1:0] pat, int plen, int target);
      logic [BYTE_W-1:0] text [$];
      int                r;
      int                cut;
      int                pos;
      while (text.size() < target) begin
         r = $urandom_range(0, 99);
         if (plen > 0 && r < 40) begin
            for (int k = 0; k < plen; k++) text.push_back(pat[8*k +: 8]);
         end else if (plen > 1 && r < 60) begin
            cut = $urandom_range(1, plen - 1);
            for (int k = 0; k < cut; k++) text.push_back(pat[8*k +: 8]);
         end else if (r < 85) begin
            pos = $urandom_range(0, 7);
            text.push_back(pat[8*pos +: 8]);
         end else begin
            text.push_back(BYTE_W'($urandom));
         end
      end
      send_text(text);
   endtask

   // random setting followed by a few streams
   task automatic random_phase();
      logic [CFG_W-1:0]  pat;
      logic [CFG_W-1:0]  rep;
      logic [CFG_W-1:0]  noise_p;
      logic [CFG_W-1:0]  noise_r;
      logic [BYTE_W-1:0] sym_a;
      logic [BYTE_W-1:0] sym_b;
      int                plen;
      int                rlen;
      int                r;
      sym_a   = BYTE_W'($urandom);
      sym_b   = BYTE_W'($urandom);
      rep     = {$urandom, $urandom};
      noise_p = {$urandom, $urandom};
      noise_r = {$urandom, $urandom};
      case ($urandom_range(0, 2))
         0: pat = {$urandom, $urandom};
         1: for (int k = 0; k < 8; k++) pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
         default: pat = {8{sym_a}};
      endcase
      r = $urandom_range(0, 19);
      if (r == 0) plen = 0;
      else if (r < 3) plen = $urandom_range(9, 15);
      else plen = $urandom_range(1, 8);
      rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      program_regs(pat, {noise_p[CFG_W-1:LEN_W], LEN_W'(plen)},
                   rep, {noise_r[CFG_W-1:LEN_W], LEN_W'(rlen)});
      repeat ($urandom_range(1, 3))
         random_stream(pat, (plen > LEN_CAP) ? LEN_CAP : plen, $urandom_range(1, 24));
      settle();
   endtask

   initial begin
      logic [BYTE_W-1:0] text [$];
      int                random_goal;
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_in_byte     = '0;
      req_stream_last = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_PATTERN_BYTES;
      csr_wdata       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty pattern: error markers, with and without stream end
      program_regs(64'h0, 64'd0, 64'h4241, 64'd2);
      text = {8'h00, 8'hFF};
      send_text(text);
      settle();

      // "ab" -> "XYZ", one hit mid-stream and one on the last byte
      program_regs(64'h6261, 64'd2, 64'h5A5958, 64'd3);
      text = {8'h78, 8'h61, 8'h62, 8'h79, 8'h61, 8'h62};
      send_text(text);
      settle();

      // deletion ending the stream: nothing left, bare end marker
      program_regs(64'h6261, 64'd2, 64'h0, 64'd0);
      text = {8'h61, 8'h62};
      send_text(text);
      settle();

      // oversized lengths clamp to eight: eight-byte burst, then flush
      program_regs(64'h0, 64'd15, {64{1'b1}}, 64'd12);
      text = {};
      repeat (8) text.push_back(8'h00);
      text.push_back(8'h01);
      send_text(text);
      settle();

      // pattern equal to replacement leaves the text as it is
      program_regs(64'h7A7A, 64'd2, 64'h7A7A, 64'd2);
      text = {8'h7A, 8'h7A, 8'h7A};
      send_text(text);
      settle();

      // register write in the middle of a stream drops the held byte
      program_regs(64'h6261, 64'd2, 64'h5A5958, 64'd3);
      send_byte(8'h61, 1'b0);
      settle();
      program_regs(64'h6261, 64'd2, 64'h5A5958, 64'd3);
      send_byte(8'h62, 1'b1);
      settle();

      // random settings and streams
      random_goal = sb.bytes_in + RANDOM_BYTES;
      while (sb.bytes_in < random_goal) random_phase();
      settle();

      $display("run covered %0d text bytes in %0d streams under %0d register settings",
               sb.bytes_in, sb.streams, settings_used);
      $display("%0d results checked, %0d pattern hits replaced, %0d mismatches",
               sb.results, sb.replacements, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("stream_find_replace_tb: clean");
      else
         $display("stream_find_replace_tb: errors");
      $finish;
   end

endmodule

// File: stream_find_replace.f
rtl/sfr_pkg.sv
rtl/sfr_cell.sv
rtl/sfr_window.sv
rtl/sfr_burst.sv
rtl/stream_find_replace.sv
tb/stream_find_replace_tb.sv
